### design/rns_pkg.sv
// Package for the regulatory network successor block.
// Holds command, status and register codes, sizes and a small helper.
// No dependencies.
package rns_pkg;

    localparam int NODES      = 8;
    localparam int SLOT_COUNT = 4;
    localparam int LEVEL_BITS = 2;
    localparam int NODE_W     = 3;
    localparam int SLOT_W     = 2;
    localparam int PAT_W      = SLOT_COUNT;
    localparam int IDX_W      = 16;

    typedef enum logic [1:0] {
        CMD_EDGE   = 2'd0,
        CMD_TABLE  = 2'd1,
        CMD_EXPAND = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_SUCC     = 2'd0,
        ST_FIX_SELF = 2'd1,
        ST_FIX_NONE = 2'd2,
        ST_BAD_IDX  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        REG_ASYNC  = 2'd0,
        REG_NODES  = 2'd1,
        REG_LEVELS = 2'd2,
        REG_SPARE  = 2'd3
    } reg_idx_t;

    // Top level of a node, taken from the packed level codes.
    function automatic logic [LEVEL_BITS-1:0] top_of(input logic [15:0] codes,
                                                     input logic [NODE_W-1:0] n);
        logic [15:0] sh;
        sh = codes >> ({1'b0, n} * LEVEL_BITS);
        return sh[LEVEL_BITS-1:0];
    endfunction

endpackage

### design/rns_tbl_ram.sv
// Target-level table memory: one write port, one registered read port.
// Depends on rns_pkg.
module rns_tbl_ram (
    input  logic                                         aclk,
    input  logic                                         wr_en,
    input  logic [rns_pkg::NODE_W+rns_pkg::PAT_W-1:0]    wr_addr,
    input  logic [rns_pkg::LEVEL_BITS-1:0]               wr_data,
    input  logic [rns_pkg::NODE_W+rns_pkg::PAT_W-1:0]    rd_addr,
    output logic [rns_pkg::LEVEL_BITS-1:0]               rd_data
);
    localparam int DEPTH = 1 << (rns_pkg::NODE_W + rns_pkg::PAT_W);

    logic [rns_pkg::LEVEL_BITS-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

### design/regulatory_network_successor_top.sv
// Successor generator for a multivalued regulatory network.
// Depends on rns_pkg and rns_tbl_ram.
//
//  channel   ports                          contents
//  in        s_tvalid s_tready s_tdata      node,slot,edge_valid,source_node,threshold,
//            s_tuser                        table_index,table_level,state_index; cmd
//  out       m_tvalid m_tready m_tdata      successor_index,changed_node; status; last
//            m_tuser m_tlast
//  cfg       cfg_wr_en cfg_addr cfg_wdata   async_mode, node_count, level_codes
//
// Write commands complete when accepted. An expand first decodes the state index node by node, then
// does the edge walk, table read and step for each node, at the pace of the one-edge-per-cycle
// sequencer and the single table read port.
// Reset (aresetn low, synchronous) resets the control, config and output valid registers and clears
// the edge present bits. A full output register stalls the sequencer; s_tready is low in an expand.
module regulatory_network_successor_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [2:0] node, [4:3] slot, [5] edge_valid, [8:6] source_node, [12:9] threshold,
    // [16:13] table_index, [18:17] table_level, [34:19] state_index
    input  logic [39:0] s_tdata,
    // [1:0] cmd
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [15:0] successor_index, [18:16] changed_node
    output logic [23:0] m_tdata,
    // [1:0] status
    output logic [1:0]  m_tuser,
    output logic        m_tlast,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [15:0] cfg_wdata
);
    localparam int NW = rns_pkg::NODE_W;
    localparam int LB = rns_pkg::LEVEL_BITS;
    localparam int EW = rns_pkg::NODE_W + rns_pkg::SLOT_W;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_DECODE = 6'b000010,
        S_EDGE   = 6'b000100,
        S_TREAD  = 6'b001000,
        S_APPLY  = 6'b010000,
        S_FINISH = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic        async_reg;
    logic [3:0]  nodes_reg;
    logic [15:0] levels_reg;

    logic [31:0]   edge_present_reg;
    logic [NW-1:0] edge_src_mem [32];
    logic [3:0]    edge_th_mem  [32];

    logic [LB-1:0] lv_reg [rns_pkg::NODES];
    logic [15:0]   wt_reg [rns_pkg::NODES];

    logic [NW-1:0] n_reg, n_next;
    logic [1:0]    s_reg, s_next;
    logic [3:0]    pat_reg, pat_next;
    logic [15:0]   rem_reg, rem_next;
    logic [15:0]   w_reg, w_next;
    logic [15:0]   sidx_reg, sidx_next;
    logic [15:0]   acc_reg, acc_next;
    logic          moved_reg, moved_next;
    logic          bad_reg, bad_next;
    logic          pend_v_reg, pend_v_next;
    logic [15:0]   pend_succ_reg, pend_succ_next;
    logic [NW-1:0] pend_node_reg, pend_node_next;

    logic          m_valid_reg;
    logic [15:0]   m_succ_reg;
    logic [NW-1:0] m_chg_reg;
    logic [1:0]    m_st_reg;
    logic          m_last_reg;

    // input fields
    logic [1:0]  in_cmd;
    logic [2:0]  in_node;
    logic [1:0]  in_slot;
    logic        in_ev;
    logic [2:0]  in_src;
    logic [3:0]  in_th;
    logic [3:0]  in_ti;
    logic [1:0]  in_tl;
    logic [15:0] in_sidx;
    logic        s_acc;

    assign in_cmd  = s_tuser;
    assign in_node = s_tdata[2:0];
    assign in_slot = s_tdata[4:3];
    assign in_ev   = s_tdata[5];
    assign in_src  = s_tdata[8:6];
    assign in_th   = s_tdata[12:9];
    assign in_ti   = s_tdata[16:13];
    assign in_tl   = s_tdata[18:17];
    assign in_sidx = s_tdata[34:19];

    assign s_tready = (state_reg == S_IDLE);
    assign s_acc    = s_tvalid && s_tready;

    // nodes in use, clamped to 1..NODES
    logic [3:0]    cnt;
    logic [NW-1:0] last_n;
    always_comb begin
        if (nodes_reg == 4'd0) begin
            cnt = 4'd1;
        end else if (nodes_reg > 4'(rns_pkg::NODES)) begin
            cnt = 4'(rns_pkg::NODES);
        end else begin
            cnt = nodes_reg;
        end
    end
    assign last_n = NW'(cnt - 4'd1);

    // table memory
    logic [LB-1:0] tbl_q;
    logic          tbl_we;
    assign tbl_we = s_acc && (in_cmd == rns_pkg::CMD_TABLE);

    rns_tbl_ram u_tbl (
        .aclk    (aclk),
        .wr_en   (tbl_we),
        .wr_addr ({in_node, in_ti[rns_pkg::PAT_W-1:0]}),
        .wr_data (in_tl),
        .rd_addr ({n_reg, pat_reg}),
        .rd_data (tbl_q)
    );

    // shared step unit signals
    logic [LB-1:0] top_n;
    logic [15:0]   q;
    logic [LB-1:0] digit;
    logic [32:0]   prod3;
    logic [15:0]   q3x;
    logic [15:0]   w_mul;
    logic [EW-1:0] e_addr;
    logic [NW-1:0] e_src;
    logic [3:0]    e_th;
    logic [NW-1:0] lv_addr;
    logic [LB-1:0] lv_rd;
    logic [LB-1:0] e_lvl;
    logic          e_act;
    logic [4:0]    e_mag;
    logic [LB-1:0] img;
    logic          up, dn;
    logic [15:0]   stepped;
    logic          out_free;
    logic          out_load;
    logic [15:0]   out_succ;
    logic [NW-1:0] out_chg;
    logic [1:0]    out_st;
    logic          out_last;

    assign top_n = rns_pkg::top_of(levels_reg, n_reg);
    assign prod3 = {1'b0, rem_reg} * 33'd43691;
    assign q3x   = q + {q[14:0], 1'b0};

    always_comb begin
        case (top_n)
            2'd0: begin
                q = rem_reg;  digit = 2'd0;         w_mul = w_reg;
            end
            2'd1: begin
                q = {1'b0, rem_reg[15:1]}; digit = {1'b0, rem_reg[0]};
                w_mul = {w_reg[14:0], 1'b0};
            end
            2'd2: begin
                q = prod3[32:17]; digit = LB'(rem_reg - q3x);
                w_mul = w_reg + {w_reg[14:0], 1'b0};
            end
            default: begin
                q = {2'b0, rem_reg[15:2]}; digit = rem_reg[1:0];
                w_mul = {w_reg[13:0], 2'b0};
            end
        endcase
    end

    assign e_addr  = {n_reg, s_reg};
    assign e_src   = edge_src_mem[e_addr];
    assign e_th    = edge_th_mem[e_addr];
    assign lv_addr = (state_reg == S_APPLY) ? n_reg : e_src;
    assign lv_rd   = lv_reg[lv_addr];
    assign e_lvl   = ({1'b0, e_src} < cnt) ? lv_rd : '0;
    assign e_mag   = 5'd16 - {1'b0, e_th};

    always_comb begin
        if (e_th == 4'd0) begin
            e_act = 1'b0;
        end else if (!e_th[3]) begin
            e_act = {2'b0, e_lvl} >= e_th;
        end else begin
            e_act = {3'b0, e_lvl} < e_mag;
        end
    end

    assign img     = (tbl_q > top_n) ? top_n : tbl_q;
    assign up      = img > lv_rd;
    assign dn      = img < lv_rd;
    assign stepped = up ? (sidx_reg + wt_reg[n_reg]) : (sidx_reg - wt_reg[n_reg]);
    assign out_free = !m_valid_reg || m_tready;

    always_comb begin
        state_next     = state_reg;
        n_next         = n_reg;
        s_next         = s_reg;
        pat_next       = pat_reg;
        rem_next       = rem_reg;
        w_next         = w_reg;
        sidx_next      = sidx_reg;
        acc_next       = acc_reg;
        moved_next     = moved_reg;
        bad_next       = bad_reg;
        pend_v_next    = pend_v_reg;
        pend_succ_next = pend_succ_reg;
        pend_node_next = pend_node_reg;
        out_load       = 1'b0;
        out_succ       = pend_succ_reg;
        out_chg        = pend_node_reg;
        out_st         = rns_pkg::ST_SUCC;
        out_last       = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (s_acc && in_cmd == rns_pkg::CMD_EXPAND) begin
                    state_next  = S_DECODE;
                    n_next      = last_n;
                    rem_next    = in_sidx;
                    w_next      = 16'd1;
                    sidx_next   = in_sidx;
                    acc_next    = in_sidx;
                    moved_next  = 1'b0;
                    pend_v_next = 1'b0;
                end
            end
            S_DECODE: begin
                rem_next = q;
                w_next   = w_mul;
                if (n_reg == '0) begin
                    bad_next = (q != 16'd0);
                    s_next   = '0;
                    pat_next = '0;
                    state_next = (q != 16'd0) ? S_FINISH : S_EDGE;
                end else begin
                    n_next = n_reg - NW'(1);
                end
            end
            S_EDGE: begin
                if (edge_present_reg[e_addr] && e_act) begin
                    pat_next = pat_reg | (4'd1 << s_reg);
                end
                s_next = s_reg + 2'd1;
                if (s_reg == 2'(rns_pkg::SLOT_COUNT - 1)) begin
                    state_next = S_TREAD;
                end
            end
            S_TREAD: begin
                state_next = S_APPLY;
            end
            S_APPLY: begin
                if (async_reg && (up || dn) && pend_v_reg && !out_free) begin
                    state_next = S_APPLY;
                end else begin
                    if (!async_reg) begin
                        if (up) begin
                            acc_next = acc_reg + wt_reg[n_reg];
                        end else if (dn) begin
                            acc_next = acc_reg - wt_reg[n_reg];
                        end
                        moved_next = moved_reg || up || dn;
                    end else if (up || dn) begin
                        out_load       = pend_v_reg;
                        pend_v_next    = 1'b1;
                        pend_succ_next = stepped;
                        pend_node_next = n_reg;
                    end
                    s_next   = '0;
                    pat_next = '0;
                    if (n_reg == last_n) begin
                        state_next = S_FINISH;
                    end else begin
                        n_next     = n_reg + NW'(1);
                        state_next = S_EDGE;
                    end
                end
            end
            S_FINISH: begin
                out_last = 1'b1;
                if (bad_reg) begin
                    out_succ = sidx_reg; out_chg = '0; out_st = rns_pkg::ST_BAD_IDX;
                end else if (!async_reg) begin
                    out_succ = acc_reg; out_chg = '0;
                    out_st = moved_reg ? rns_pkg::ST_SUCC : rns_pkg::ST_FIX_SELF;
                end else if (!pend_v_reg) begin
                    out_succ = sidx_reg; out_chg = '0; out_st = rns_pkg::ST_FIX_NONE;
                end
                if (out_free) begin
                    out_load    = 1'b1;
                    pend_v_next = 1'b0;
                    bad_next    = 1'b0;
                    state_next  = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_IDLE;
            async_reg        <= 1'b0;
            nodes_reg        <= 4'd8;
            levels_reg       <= 16'h5555;
            edge_present_reg <= '0;
            pend_v_reg       <= 1'b0;
            bad_reg          <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg  <= state_next;
            pend_v_reg <= pend_v_next;
            bad_reg    <= bad_next;
            if (cfg_wr_en) begin
                case (cfg_addr)
                    rns_pkg::REG_ASYNC:  async_reg  <= cfg_wdata[0];
                    rns_pkg::REG_NODES:  nodes_reg  <= cfg_wdata[3:0];
                    rns_pkg::REG_LEVELS: levels_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            if (s_acc && in_cmd == rns_pkg::CMD_EDGE) begin
                edge_present_reg[{in_node, in_slot}] <= in_ev;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload and working registers
    always_ff @(posedge aclk) begin
        n_reg         <= n_next;
        s_reg         <= s_next;
        pat_reg       <= pat_next;
        rem_reg       <= rem_next;
        w_reg         <= w_next;
        sidx_reg      <= sidx_next;
        acc_reg       <= acc_next;
        moved_reg     <= moved_next;
        pend_succ_reg <= pend_succ_next;
        pend_node_reg <= pend_node_next;
        if (s_acc && in_cmd == rns_pkg::CMD_EDGE) begin
            edge_src_mem[{in_node, in_slot}] <= in_src;
            edge_th_mem[{in_node, in_slot}]  <= in_th;
        end
        if (state_reg == S_DECODE) begin
            lv_reg[n_reg] <= digit;
            wt_reg[n_reg] <= w_reg;
        end
        if (out_load) begin
            m_succ_reg <= out_succ;
            m_chg_reg  <= out_chg;
            m_st_reg   <= out_st;
            m_last_reg <= out_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'd0, m_chg_reg, m_succ_reg};
    assign m_tuser  = m_st_reg;
    assign m_tlast  = m_last_reg;

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> out_free) else $error("output item overwritten");
    a_pend_async: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_v_reg |-> async_reg) else $error("pending item in synchronous mode");
    a_expand_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && in_cmd == rns_pkg::CMD_EXPAND) |=> !s_tready)
        else $error("ready after expand accepted");
    a_finish_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FINISH && out_load) |=> (m_tvalid && m_tlast))
        else $error("final item missing last");
`endif
endmodule
